FILE: src/life_like_automaton_step_defines.svh
// Assertion macros shared by the cell automaton RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LIFE_LIKE_AUTOMATON_STEP_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_STEP_DEFINES_SVH

// Condition must hold at every clock edge outside reset
`define LLA_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define LLA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LLA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lla_pkg.sv
// Shared constants, types and codes for the cell automaton block.
// No dependencies; imported by every module except the generic RAM.
`default_nettype none

package lla_pkg;

    // Grid geometry
    localparam int GRID_WIDTH  = 128;
    localparam int GRID_HEIGHT = 64;
    localparam int COL_AW      = $clog2(GRID_WIDTH);
    localparam int ROW_AW      = $clog2(GRID_HEIGHT);
    localparam int CNT_W       = $clog2(GRID_HEIGHT + 2);

    // Field widths of the stream payloads
    localparam int OP_W        = 2;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // Configuration port
    localparam int CFG_W = 4;
    localparam int IDX_W = 2;

    // Row sweep counter marks
    localparam logic [CNT_W-1:0] CNT_CLEAR_LAST = CNT_W'(GRID_HEIGHT - 1);
    localparam logic [CNT_W-1:0] CNT_ROWS       = CNT_W'(GRID_HEIGHT);
    localparam logic [CNT_W-1:0] CNT_ADV_LAST   = CNT_W'(GRID_HEIGHT + 1);
    localparam logic [CNT_W-1:0] CNT_ONE        = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO        = CNT_W'(2);

    typedef logic [GRID_WIDTH-1:0] row_t;
    typedef logic [CFG_W-1:0]      count_t;

    typedef enum logic [OP_W-1:0] {
        OP_TOGGLE  = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SURVIVE_LOW  = 2'd0,
        REG_SURVIVE_HIGH = 2'd1,
        REG_BIRTH_COUNT  = 2'd2
    } reg_idx_t;

    localparam count_t SURVIVE_LOW_RST  = 4'd2;
    localparam count_t SURVIVE_HIGH_RST = 4'd3;
    localparam count_t BIRTH_COUNT_RST  = 4'd3;

    // Rule settings handed to the row update logic
    typedef struct packed {
        count_t survive_low;
        count_t survive_high;
        count_t birth_count;
    } rule_cfg_t;

endpackage

`default_nettype wire

FILE: src/lla_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: src/lla_row_rule.sv
// Next-generation logic for one grid row: one counting lane per column.
// Depends on lla_pkg (row_t, count_t, rule_cfg_t).
`default_nettype none

module lla_row_rule
    import lla_pkg::*;
(
    input  wire row_t      above,
    input  wire row_t      mid,
    input  wire row_t      below,
    input  wire rule_cfg_t cfg,
    output row_t           next_row
);

    // Pad the rows with dead cells beyond both edges
    logic [GRID_WIDTH+1:0] above_pad;
    logic [GRID_WIDTH+1:0] mid_pad;
    logic [GRID_WIDTH+1:0] below_pad;

    assign above_pad = {1'b0, above, 1'b0};
    assign mid_pad   = {1'b0, mid, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    // Count the eight neighbors of each column and apply the rule
    for (genvar c = 0; c < GRID_WIDTH; c++)
    begin : g_lane
        count_t nbr;

        assign nbr = count_t'(above_pad[c]) + count_t'(above_pad[c+1])
                   + count_t'(above_pad[c+2]) + count_t'(mid_pad[c])
                   + count_t'(mid_pad[c+2]) + count_t'(below_pad[c])
                   + count_t'(below_pad[c+1]) + count_t'(below_pad[c+2]);

        assign next_row[c] = mid[c]
            ? ((nbr >= cfg.survive_low) && (nbr <= cfg.survive_high))
            : (nbr == cfg.birth_count);
    end

endmodule

`default_nettype wire

FILE: src/life_like_automaton_step.sv
// Top level of the cell automaton: row-wide ping-pong grid banks and sequencer.
// Depends on lla_pkg, lla_ram, lla_row_rule and life_like_automaton_step_defines.svh.
//
//  Channel  | Signals                              | Moves
//  ---------+--------------------------------------+----------------------------------
//  s        | s_tvalid s_tready s_tdata[15:0]      | one command (op, col, row)
//  m        | m_tvalid m_tready m_tdata[7:0]       | one result (cell_value)
//  cfg      | cfg_we cfg_index[1:0] cfg_wdata[3:0] | one rule register write
//
// Each bank holds one grid row per word, so a toggle or read passes through S_MOD and S_DONE
// after acceptance, and a generation step sweeps the rows in S_ADV before S_DONE,
// with one row read per cycle from the current bank's read port.
// After reset a clearing pass writes zero to all GRID_HEIGHT rows of both banks;
// no command is taken then, configuration writes are.
// A stalled result holds the sequencer only after the next command has finished.
`default_nettype none
`include "life_like_automaton_step_defines.svh"

module life_like_automaton_step
    import lla_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // op[1:0], col[8:2], row[14:9], zero
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,   // cell_value[0], zero
    input  wire logic                   cfg_we,
    input  wire logic [IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_wdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_ADV,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              current_bank_reg, current_bank_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_value_reg, m_value_next;
    logic              result_reg, result_next;
    logic              result_load;

    count_t            survive_low_reg, survive_high_reg, birth_count_reg;
    rule_cfg_t         rule_cfg;

    op_t               op_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    row_t              prev_row_reg, cur_row_reg;

    logic [OP_W-1:0]   in_op;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;
    logic              accept;
    logic              adv_shift;

    logic              ram_a_we, ram_b_we;
    logic              we_cur, we_oth, we_both;
    logic [ROW_AW-1:0] raddr, waddr;
    row_t              wdata;
    row_t              rdata_a, rdata_b, rd_row;
    row_t              below_row, rule_row, col_mask;
    logic [COL_AW-1:0] col_idx;
    logic              cell_inside;

    // Unpack the command fields
    assign in_op  = s_tdata[OP_W-1:0];
    assign in_col = s_tdata[OP_W +: COL_W];
    assign in_row = s_tdata[OP_W+COL_W +: ROW_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, m_value_reg};

    // Rule registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            survive_low_reg  <= SURVIVE_LOW_RST;
            survive_high_reg <= SURVIVE_HIGH_RST;
            birth_count_reg  <= BIRTH_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SURVIVE_LOW:  survive_low_reg  <= cfg_wdata;
                REG_SURVIVE_HIGH: survive_high_reg <= cfg_wdata;
                REG_BIRTH_COUNT:  birth_count_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    assign rule_cfg = '{survive_low:  survive_low_reg,
                        survive_high: survive_high_reg,
                        birth_count:  birth_count_reg};

    // Grid banks, one row per word
    lla_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_bank_a (
        .clk   (clk),
        .we    (ram_a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    lla_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_bank_b (
        .clk   (clk),
        .we    (ram_b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    // Route writes to the current or the other bank
    assign ram_a_we = we_both || (we_cur && !current_bank_reg) || (we_oth && current_bank_reg);
    assign ram_b_we = we_both || (we_cur && current_bank_reg) || (we_oth && !current_bank_reg);
    assign rd_row   = current_bank_reg ? rdata_b : rdata_a;

    // Cell addressing for toggle and read
    assign col_idx     = COL_AW'(col_reg);
    assign col_mask    = row_t'(1) << col_idx;
    assign cell_inside = (int'(col_reg) < GRID_WIDTH) && (int'(row_reg) < GRID_HEIGHT);

    // Bottom neighbor row during the sweep; dead past the last row
    assign below_row = (cnt_reg <= CNT_ROWS) ? rd_row : '0;

    lla_row_rule u_row_rule (
        .above    (prev_row_reg),
        .mid      (cur_row_reg),
        .below    (below_row),
        .cfg      (rule_cfg),
        .next_row (rule_row)
    );

    // Sequencer next-state, memory control and result
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        current_bank_next = current_bank_reg;
        m_valid_next      = m_valid_reg;
        m_value_next      = m_value_reg;
        result_next       = 1'b0;
        result_load       = 1'b0;
        adv_shift         = 1'b0;
        we_cur            = 1'b0;
        we_oth            = 1'b0;
        we_both           = 1'b0;
        raddr             = ROW_AW'(row_reg);
        waddr             = ROW_AW'(row_reg);
        wdata             = rd_row ^ col_mask;

        // Drop the result once taken
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                we_both = 1'b1;
                waddr   = ROW_AW'(cnt_reg);
                wdata   = '0;
                cnt_next = cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_CLEAR_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                raddr = ROW_AW'(in_row);
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = (op_t'(in_op) == OP_ADVANCE) ? S_ADV : S_MOD;
                end
            end
            S_MOD:
            begin
                result_load = 1'b1;
                case (op_reg)
                    OP_TOGGLE:
                    begin
                        we_cur      = cell_inside;
                        result_next = cell_inside && !rd_row[col_idx];
                    end
                    OP_READ:
                    begin
                        result_next = cell_inside && rd_row[col_idx];
                    end
                    default:
                    begin
                        result_next = 1'b0;
                    end
                endcase
                state_next = S_DONE;
            end
            S_ADV:
            begin
                raddr     = ROW_AW'(cnt_reg);
                waddr     = ROW_AW'(cnt_reg - CNT_TWO);
                wdata     = rule_row;
                we_oth    = (cnt_reg >= CNT_TWO);
                adv_shift = (cnt_reg >= CNT_ONE);
                cnt_next  = cnt_reg + CNT_ONE;
                if (cnt_reg == CNT_ADV_LAST)
                begin
                    cnt_next          = '0;
                    current_bank_next = !current_bank_reg;
                    result_load       = 1'b1;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_value_next = result_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, counter, bank select and the output result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            cnt_reg          <= '0;
            current_bank_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_value_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            current_bank_reg <= current_bank_next;
            m_valid_reg      <= m_valid_next;
            m_value_reg      <= m_value_next;
        end
    end

    // Capture the command, load the result and advance the row window
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(in_op);
            col_reg <= in_col;
            row_reg <= in_row;
        end
        if (result_load)
        begin
            result_reg <= result_next;
        end
        if (accept && (op_t'(in_op) == OP_ADVANCE))
        begin
            prev_row_reg <= '0;
            cur_row_reg  <= '0;
        end
        else if (adv_shift)
        begin
            prev_row_reg <= cur_row_reg;
            cur_row_reg  <= below_row;
        end
    end

    `LLA_ASSERT_SAME(a_no_accept_in_clear, state_reg == S_CLEAR, !s_tready,
        "command taken during clear")
    `LLA_ASSERT_SAME(a_dual_write_clear_only, ram_a_we && ram_b_we, state_reg == S_CLEAR,
        "both banks written outside clear")
    `LLA_ASSERT_NEXT(a_bank_flip_at_end, (state_reg == S_ADV) && (cnt_reg == CNT_ADV_LAST),
        current_bank_reg != $past(current_bank_reg), "bank did not flip after sweep")
    `LLA_ASSERT_NEXT(a_bank_steady, !((state_reg == S_ADV) && (cnt_reg == CNT_ADV_LAST)),
        $stable(current_bank_reg), "bank changed outside sweep end")

endmodule

`default_nettype wire
